/* hw/rtl/ssmd_pkg.sv */
// Shared types and constants for the seven-segment multiplexed display block.
// Used by ssmd_ctrl, ssmd_dp and seven_segment_mux_display_top.
`timescale 1ns / 1ps

package ssmd_pkg;

  localparam int DIGIT_SLOTS = 8;

  localparam logic [2:0] KIND_TICK  = 3'd0;
  localparam logic [2:0] KIND_DEC   = 3'd1;
  localparam logic [2:0] KIND_HEX   = 3'd2;
  localparam logic [2:0] KIND_RAW   = 3'd3;
  localparam logic [2:0] KIND_DP    = 3'd4;
  localparam logic [2:0] KIND_CLEAR = 3'd5;

  localparam logic REG_NDIGITS  = 1'b0;
  localparam logic REG_POLARITY = 1'b1;

  localparam logic [7:0] GLYPH_BLANK = 8'h00;
  localparam logic [7:0] GLYPH_MINUS = 8'h40;

  localparam logic [31:0] RECIP_10 = 32'hCCCC_CCCD;

  localparam logic [32:0] POW10 [0:8] = '{
    33'd1, 33'd10, 33'd100, 33'd1000, 33'd10000, 33'd100000,
    33'd1000000, 33'd10000000, 33'd100000000
  };

  localparam logic [32:0] POW16 [0:8] = '{
    33'h0_0000_0001, 33'h0_0000_0010, 33'h0_0000_0100, 33'h0_0000_1000,
    33'h0_0001_0000, 33'h0_0010_0000, 33'h0_0100_0000, 33'h0_1000_0000,
    33'h1_0000_0000
  };

  typedef struct packed {
    logic load;
    logic exec;
    logic step;
    logic publish;
  } ssmd_cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       range_ok;
    logic       last_step;
  } ssmd_stat_t;

  function automatic logic [7:0] glyph(input logic [3:0] d);
    logic [7:0] g;
    case (d)
      4'h0: g = 8'h3F;
      4'h1: g = 8'h06;
      4'h2: g = 8'h5B;
      4'h3: g = 8'h4F;
      4'h4: g = 8'h66;
      4'h5: g = 8'h6D;
      4'h6: g = 8'h7D;
      4'h7: g = 8'h07;
      4'h8: g = 8'h7F;
      4'h9: g = 8'h6F;
      4'hA: g = 8'h77;
      4'hB: g = 8'h7C;
      4'hC: g = 8'h39;
      4'hD: g = 8'h5E;
      4'hE: g = 8'h79;
      4'hF: g = 8'h71;
      default: g = GLYPH_BLANK;
    endcase
    return g;
  endfunction

endpackage

/* hw/rtl/ssmd_ctrl.sv */
// Controller state machine for the seven-segment display block.
// Depends on ssmd_pkg; drives ssmd_dp through command/status structs.
`timescale 1ns / 1ps

module ssmd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  ssmd_pkg::ssmd_stat_t stat,
  output ssmd_pkg::ssmd_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_CONV,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   is_write;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign is_write  = (stat.kind == ssmd_pkg::KIND_DEC) || (stat.kind == ssmd_pkg::KIND_HEX);

  always_comb begin
    cmd.load    = (state_r == S_IDLE) && in_valid;
    cmd.exec    = (state_r == S_EXEC);
    cmd.step    = (state_r == S_CONV);
    cmd.publish = (state_r == S_DONE) && (!out_valid_r || out_ready);
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (is_write && stat.range_ok) state_nxt = S_CONV;
        else state_nxt = S_DONE;
      end
      S_CONV: begin
        if (stat.last_step) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (cmd.publish) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* hw/rtl/ssmd_dp.sv */
// Datapath: digit buffer, active index, digit conversion and output registers.
// Depends on ssmd_pkg; sequenced by ssmd_ctrl.
`timescale 1ns / 1ps

module ssmd_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ssmd_pkg::ssmd_cmd_t  cmd,
  output ssmd_pkg::ssmd_stat_t stat,
  input  logic [3:0]           used_n,
  input  logic                 ca_mode,
  input  logic [2:0]           in_kind,
  input  logic signed [32:0]   in_number,
  input  logic                 in_leading_zeros,
  input  logic [2:0]           in_digit_index,
  input  logic [7:0]           in_segment_byte,
  input  logic [7:0]           in_dp_mask,
  output logic                 out_status,
  output logic [7:0]           out_segment_levels,
  output logic [7:0]           out_digit_enables,
  output logic [2:0]           out_cur_digit
);

  localparam int ND = ssmd_pkg::DIGIT_SLOTS;

  logic [2:0]  kind_r;
  logic [32:0] num_r;
  logic        lz_r;
  logic [2:0]  idx_r;
  logic [7:0]  seg_r;
  logic [7:0]  mask_r;

  logic [7:0]  digit_buf_r [ND];
  logic [7:0]  digit_buf_nxt [ND];
  logic [2:0]  act_r, act_nxt;
  logic        status_r, status_nxt;

  logic [31:0] val_r, val_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic        first_r, first_nxt;
  logic        minus_r, minus_nxt;
  logic        hex_r, hex_nxt;

  logic [7:0]  o_seg_r;
  logic [7:0]  o_en_r;
  logic [2:0]  o_act_r;
  logic        o_status_r;

  logic        neg;
  logic [32:0] mag;
  logic [3:0]  places;
  logic        dec_ok;
  logic        hex_ok;
  logic        range_ok;
  logic [63:0] prod;
  logic [31:0] quot;
  logic [31:0] rem32;
  logic [7:0]  step_byte;
  logic [31:0] step_val;
  logic [7:0]  cur_byte;
  logic [7:0]  onehot;

  function automatic logic [2:0] next_index(input logic [2:0] a, input logic [3:0] n);
    logic [3:0] r;
    r = {1'b0, a} + 4'd1;
    for (int i = 0; i < ND; i++) begin
      if (r >= n) r = r - n;
    end
    return r[2:0];
  endfunction

  assign neg      = num_r[32];
  assign mag      = neg ? (33'd0 - num_r) : num_r;
  assign places   = neg ? (used_n - 4'd1) : used_n;
  assign dec_ok   = mag < ssmd_pkg::POW10[places];
  assign hex_ok   = num_r < ssmd_pkg::POW16[used_n];
  assign range_ok = (kind_r == ssmd_pkg::KIND_DEC) ? dec_ok : hex_ok;

  assign stat.kind      = kind_r;
  assign stat.range_ok  = range_ok;
  assign stat.last_step = (pos_r == 3'd0);

  // divide by 10 through reciprocal multiply
  assign prod  = 64'(val_r) * 64'(ssmd_pkg::RECIP_10);
  assign quot  = 32'(prod[63:35]);
  assign rem32 = val_r - ((quot << 3) + (quot << 1));

  always_comb begin
    step_val  = val_r;
    minus_nxt = minus_r;
    if (hex_r) begin
      step_byte = ssmd_pkg::glyph(val_r[3:0]);
      step_val  = val_r >> 4;
    end else if (val_r != 32'd0 || first_r) begin
      step_byte = ssmd_pkg::glyph(rem32[3:0]);
      step_val  = quot;
    end else if (minus_r) begin
      step_byte = ssmd_pkg::GLYPH_MINUS;
      minus_nxt = 1'b0;
    end else begin
      step_byte = lz_r ? ssmd_pkg::glyph(4'd0) : ssmd_pkg::GLYPH_BLANK;
    end
  end

  always_comb begin
    digit_buf_nxt = digit_buf_r;
    act_nxt       = act_r;
    status_nxt    = status_r;
    val_nxt       = val_r;
    pos_nxt       = pos_r;
    first_nxt     = first_r;
    hex_nxt       = hex_r;
    if (cmd.exec) begin
      status_nxt = 1'b0;
      case (kind_r)
        ssmd_pkg::KIND_TICK: act_nxt = next_index(act_r, used_n);
        ssmd_pkg::KIND_DEC, ssmd_pkg::KIND_HEX: begin
          status_nxt = !range_ok;
          hex_nxt    = (kind_r == ssmd_pkg::KIND_HEX);
          val_nxt    = (kind_r == ssmd_pkg::KIND_HEX) ? num_r[31:0] : mag[31:0];
          pos_nxt    = 3'(used_n - 4'd1);
          first_nxt  = 1'b1;
        end
        ssmd_pkg::KIND_RAW: begin
          if ({1'b0, idx_r} < used_n) digit_buf_nxt[idx_r] = seg_r;
          else status_nxt = 1'b1;
        end
        ssmd_pkg::KIND_DP: begin
          for (int i = 0; i < ND; i++) begin
            if (4'(i) < used_n) digit_buf_nxt[i][7] = mask_r[i];
          end
        end
        ssmd_pkg::KIND_CLEAR: begin
          for (int i = 0; i < ND; i++) begin
            if (4'(i) < used_n) digit_buf_nxt[i] = ssmd_pkg::GLYPH_BLANK;
          end
        end
        default: status_nxt = 1'b1;
      endcase
    end
    if (cmd.step) begin
      digit_buf_nxt[pos_r] = step_byte;
      val_nxt              = step_val;
      pos_nxt              = pos_r - 3'd1;
      first_nxt            = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ND; i++) digit_buf_r[i] <= ssmd_pkg::GLYPH_BLANK;
      act_r <= 3'd0;
    end else begin
      digit_buf_r <= digit_buf_nxt;
      act_r       <= act_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      num_r  <= in_number;
      lz_r   <= in_leading_zeros;
      idx_r  <= in_digit_index;
      seg_r  <= in_segment_byte;
      mask_r <= in_dp_mask;
    end
    if (cmd.exec) minus_r <= neg;
    else if (cmd.step) minus_r <= minus_nxt;
    status_r <= status_nxt;
    val_r    <= val_nxt;
    pos_r    <= pos_nxt;
    first_r  <= first_nxt;
    hex_r    <= hex_nxt;
  end

  assign cur_byte = digit_buf_r[act_r];
  assign onehot   = 8'd1 << act_r;

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      o_seg_r    <= ca_mode ? ~cur_byte : cur_byte;
      o_en_r     <= ca_mode ? onehot : ~onehot;
      o_act_r    <= act_r;
      o_status_r <= status_r;
    end
  end

  assign out_status         = o_status_r;
  assign out_segment_levels = o_seg_r;
  assign out_digit_enables  = o_en_r;
  assign out_cur_digit      = o_act_r;

endmodule

/* hw/rtl/seven_segment_mux_display_top.sv */
// Multiplexed seven-segment display controller, top level with APB registers.
// Depends on ssmd_pkg, ssmd_ctrl and ssmd_dp.
//
// Each accepted transaction yields exactly one result showing the pin drive
// after it is applied. Ticks, raw bytes, decimal points, clears and rejected
// items pass through accept, execute and publish states. Decimal and hex
// writes add a conversion step per digit in use, one digit per cycle,
// writing the buffer right to left: decimal digits through a reciprocal
// divide-by-10 unit, hex digits by shifting. A new transaction is taken
// once the previous one is published, while its result waits in the output
// register; a second result stalls until the first is taken. Registers:
// digit count at 0x0, segment polarity at 0x4.
`timescale 1ns / 1ps

module seven_segment_mux_display_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_kind,
  input  logic signed [32:0] in_number,
  input  logic               in_leading_zeros,
  input  logic [2:0]         in_digit_index,
  input  logic [7:0]         in_segment_byte,
  input  logic [7:0]         in_dp_mask,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_status,
  output logic [7:0]         out_segment_levels,
  output logic [7:0]         out_digit_enables,
  output logic [2:0]         out_cur_digit,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [3:0]           ndigits_r;
  logic                 ca_mode_r;
  logic [3:0]           used_n;
  logic                 reg_sel;
  ssmd_pkg::ssmd_cmd_t  cmd;
  ssmd_pkg::ssmd_stat_t stat;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ndigits_r <= 4'd8;
      ca_mode_r <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        ssmd_pkg::REG_NDIGITS:  ndigits_r <= pwdata[3:0];
        ssmd_pkg::REG_POLARITY: ca_mode_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      ssmd_pkg::REG_NDIGITS:  prdata = {28'd0, ndigits_r};
      ssmd_pkg::REG_POLARITY: prdata = {31'd0, ca_mode_r};
      default:                prdata = 32'd0;
    endcase
  end

  always_comb begin
    if (ndigits_r == 4'd0) used_n = 4'd1;
    else if (ndigits_r > 4'(ssmd_pkg::DIGIT_SLOTS)) used_n = 4'(ssmd_pkg::DIGIT_SLOTS);
    else used_n = ndigits_r;
  end

  ssmd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ssmd_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .used_n             (used_n),
    .ca_mode            (ca_mode_r),
    .in_kind            (in_kind),
    .in_number          (in_number),
    .in_leading_zeros   (in_leading_zeros),
    .in_digit_index     (in_digit_index),
    .in_segment_byte    (in_segment_byte),
    .in_dp_mask         (in_dp_mask),
    .out_status         (out_status),
    .out_segment_levels (out_segment_levels),
    .out_digit_enables  (out_digit_enables),
    .out_cur_digit      (out_cur_digit)
  );

endmodule

/* tb/tb_seven_segment_mux_display_top.sv */
// Self-checking testbench for seven_segment_mux_display_top: directed and random
// transactions with random idling on both channels, APB setup of both registers.
// Depends on ssmd_pkg and the RTL under hw/rtl.
`timescale 1ns / 1ps

module tb_seven_segment_mux_display_top;

  localparam logic [2:0] KIND_RSVD_LO = 3'd6;
  localparam logic [2:0] KIND_RSVD_HI = 3'd7;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASE_ITEMS = 200;
  localparam int PHASES = 10;

  localparam logic [7:0] SEG_FONT [16] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
    8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71
  };

  typedef struct {
    logic [2:0]  kind;
    logic [32:0] number;
    logic        lz;
    logic [2:0]  idx;
    logic [7:0]  seg;
    logic [7:0]  mask;
  } disp_cmd_t;

  typedef struct {
    logic       status;
    logic [7:0] seg;
    logic [7:0] en;
    logic [2:0] act;
  } pin_drive_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         in_kind = '0;
  logic signed [32:0] in_number = '0;
  logic               in_leading_zeros = 1'b0;
  logic [2:0]         in_digit_index = '0;
  logic [7:0]         in_segment_byte = '0;
  logic [7:0]         in_dp_mask = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_status;
  logic [7:0]         out_segment_levels;
  logic [7:0]         out_digit_enables;
  logic [2:0]         out_cur_digit;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  // predictor state
  logic [7:0] disp_buf [8];
  logic [2:0] act_idx;
  logic [3:0] cfg_count;
  logic       cfg_ca;

  pin_drive_t expected_drives [$];
  pin_drive_t want;
  int err_count = 0;
  int cycles = 0;
  bit no_idle = 1'b0;
  int hold_len = 0;
  int hold_go = 0;
  int hold_seen = 0;
  int rx_wait = 0;

  seven_segment_mux_display_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind), .in_number(in_number),
    .in_leading_zeros(in_leading_zeros), .in_digit_index(in_digit_index),
    .in_segment_byte(in_segment_byte), .in_dp_mask(in_dp_mask),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_segment_levels(out_segment_levels), .out_digit_enables(out_digit_enables),
    .out_cur_digit(out_cur_digit),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_seven_segment_mux_display_top: FAIL");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int used_digits();
    if (cfg_count == 4'd0) return 1;
    if (int'(cfg_count) > ssmd_pkg::DIGIT_SLOTS) return ssmd_pkg::DIGIT_SLOTS;
    return int'(cfg_count);
  endfunction

  task automatic predict_pin_drive(input disp_cmd_t c, output pin_drive_t d);
    logic [63:0] raw, mag, lim;
    logic [7:0]  nb [8];
    logic        neg;
    int          n, places, pos, i;
    n = used_digits();
    d.status = 1'b0;
    case (c.kind)
      ssmd_pkg::KIND_TICK: act_idx = 3'((int'(act_idx) + 1) % n);
      ssmd_pkg::KIND_DEC: begin
        raw = {31'd0, c.number};
        neg = raw[32];
        mag = neg ? (64'h2_0000_0000 - raw) : raw;
        places = neg ? n - 1 : n;
        lim = 64'd1;
        for (i = 0; i < places; i++) lim = lim * 10;
        if (mag >= lim) begin
          d.status = 1'b1;
        end else begin
          for (i = 0; i < 8; i++) nb[i] = c.lz ? SEG_FONT[0] : ssmd_pkg::GLYPH_BLANK;
          pos = n - 1;
          if (mag == 0) begin
            nb[pos] = SEG_FONT[0];
            pos--;
          end else begin
            while (mag > 0 && pos >= 0) begin
              nb[pos] = SEG_FONT[int'(mag % 10)];
              mag = mag / 10;
              pos--;
            end
          end
          if (neg && pos >= 0) nb[pos] = ssmd_pkg::GLYPH_MINUS;
          for (i = 0; i < n; i++) disp_buf[i] = nb[i];
        end
      end
      ssmd_pkg::KIND_HEX: begin
        raw = {31'd0, c.number};
        lim = 64'd1 << (4 * n);
        if (raw >= lim) begin
          d.status = 1'b1;
        end else begin
          for (i = n - 1; i >= 0; i--) begin
            disp_buf[i] = SEG_FONT[raw[3:0]];
            raw = raw >> 4;
          end
        end
      end
      ssmd_pkg::KIND_RAW: begin
        if (int'(c.idx) >= n) d.status = 1'b1;
        else disp_buf[c.idx] = c.seg;
      end
      ssmd_pkg::KIND_DP: begin
        for (i = 0; i < n; i++) disp_buf[i][7] = c.mask[i];
      end
      ssmd_pkg::KIND_CLEAR: begin
        for (i = 0; i < n; i++) disp_buf[i] = ssmd_pkg::GLYPH_BLANK;
      end
      default: d.status = 1'b1;
    endcase
    d.act = act_idx;
    if (cfg_ca) begin
      d.seg = ~disp_buf[act_idx];
      d.en = 8'h01 << act_idx;
    end else begin
      d.seg = disp_buf[act_idx];
      d.en = ~(8'h01 << act_idx);
    end
  endtask

  task automatic send_cmd(input disp_cmd_t c);
    int gap;
    pin_drive_t d;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= c.kind;
    in_number <= c.number;
    in_leading_zeros <= c.lz;
    in_digit_index <= c.idx;
    in_segment_byte <= c.seg;
    in_dp_mask <= c.mask;
    do @(posedge clk); while (!in_ready);
    predict_pin_drive(c, d);
    expected_drives.push_back(d);
  endtask

  task automatic send_op(input logic [2:0] kind, input logic [32:0] number, input logic lz,
                         input logic [2:0] idx, input logic [7:0] seg, input logic [7:0] mask);
    disp_cmd_t c;
    c.kind = kind;
    c.number = number;
    c.lz = lz;
    c.idx = idx;
    c.seg = seg;
    c.mask = mask;
    send_cmd(c);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_drives.size() > 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic reg_sel, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_sel, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_sel == ssmd_pkg::REG_NDIGITS) cfg_count = value[3:0];
    else cfg_ca = value[0];
  endtask

  task automatic set_config(input logic [3:0] count, input logic ca);
    wait_drain();
    cfg_write(ssmd_pkg::REG_NDIGITS, {28'd0, count});
    cfg_write(ssmd_pkg::REG_POLARITY, {31'd0, ca});
  endtask

  function automatic logic [32:0] pick_number(input logic [2:0] kind, input int n);
    logic [63:0] mag;
    logic        neg;
    int          r, pl, k, i;
    r = $urandom_range(0, 99);
    neg = 1'b0;
    if (r >= 85) return {1'($urandom_range(0, 1)), 32'($urandom)};
    if (kind == ssmd_pkg::KIND_HEX) begin
      if (r < 70) begin
        k = $urandom_range(0, n);
        mag = (k == 8) ? 64'($urandom) : 64'($urandom) % (64'd1 << (4 * k));
      end else begin
        mag = (64'd1 << (4 * n)) - 1 + $urandom_range(0, 1);
      end
      return mag[32:0];
    end
    neg = (r < 70) ? (n > 1 && $urandom_range(0, 2) == 0) : 1'($urandom_range(0, 1));
    pl = neg ? n - 1 : n;
    k = (r < 70) ? $urandom_range(0, pl) : pl;
    mag = 64'd1;
    for (i = 0; i < k; i++) mag = mag * 10;
    if (r < 70) mag = 64'($urandom) % mag;
    else mag = mag - 1 + $urandom_range(0, 1);
    return neg ? (33'd0 - mag[32:0]) : mag[32:0];
  endfunction

  function automatic disp_cmd_t rand_cmd(input int n);
    disp_cmd_t c;
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) c.kind = ssmd_pkg::KIND_TICK;
    else if (r < 55) c.kind = ssmd_pkg::KIND_DEC;
    else if (r < 70) c.kind = ssmd_pkg::KIND_HEX;
    else if (r < 82) c.kind = ssmd_pkg::KIND_RAW;
    else if (r < 90) c.kind = ssmd_pkg::KIND_DP;
    else if (r < 95) c.kind = ssmd_pkg::KIND_CLEAR;
    else c.kind = $urandom_range(0, 1) ? KIND_RSVD_LO : KIND_RSVD_HI;
    if (c.kind == ssmd_pkg::KIND_DEC || c.kind == ssmd_pkg::KIND_HEX)
      c.number = pick_number(c.kind, n);
    else c.number = {1'($urandom_range(0, 1)), 32'($urandom)};
    c.lz = 1'($urandom_range(0, 1));
    c.idx = ($urandom_range(0, 4) != 0) ? 3'($urandom_range(0, n - 1)) : 3'($urandom_range(0, 7));
    c.seg = 8'($urandom);
    c.mask = 8'($urandom);
    return c;
  endfunction

  always @(posedge clk) begin
    if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      rx_wait <= hold_len;
      out_ready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      out_ready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 99) < 25) begin
      rx_wait <= pick_gap();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic report_mismatch(input string field, input int got, input int exp_val);
    $display("mismatch %s: got 0x%0h, expected 0x%0h (cycle %0d)", field, got, exp_val, cycles);
    err_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_drives.size() == 0) begin
        report_mismatch("unexpected transaction", int'(out_cur_digit), 0);
      end else begin
        want = expected_drives.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", int'(out_status), int'(want.status));
        if (out_segment_levels !== want.seg)
          report_mismatch("segment_levels", int'(out_segment_levels), int'(want.seg));
        if (out_digit_enables !== want.en)
          report_mismatch("digit_enables", int'(out_digit_enables), int'(want.en));
        if (out_cur_digit !== want.act)
          report_mismatch("cur_digit", int'(out_cur_digit), int'(want.act));
      end
    end
  end

  task automatic test_writes_full_width();
    set_config(4'd8, 1'b0);
    send_op(ssmd_pkg::KIND_DEC, 33'd12345678, 1'b0, 3'd0, 8'h00, 8'h00);
    send_op(ssmd_pkg::KIND_TICK, 33'd0, 1'b0, 3'd0, 8'h00, 8'h00);
    send_op(ssmd_pkg::KIND_DEC, 33'd0 - 33'd1234567, 1'b1, 3'd0, 8'h00, 8'h00);
    send_op(ssmd_pkg::KIND_DEC, 33'd42, 1'b1, 3'd0, 8'h00, 8'h00);
    send_op(ssmd_pkg::KIND_DEC, 33'd0, 1'b0, 3'd0, 8'h00, 8'h00);
    send_op(ssmd_pkg::KIND_DEC, 33'd100000000, 1'b0, 3'd0, 8'h00, 8'h00);
    send_op(ssmd_pkg::KIND_DEC, 33'd0 - 33'd10000000, 1'b0, 3'd0, 8'h00, 8'h00);
    send_op(ssmd_pkg::KIND_DEC, 33'h1_0000_0000, 1'b1, 3'd0, 8'h00, 8'h00);
    send_op(ssmd_pkg::KIND_DEC, 33'h1_8000_0000, 1'b1, 3'd0, 8'h00, 8'h00);
    send_op(ssmd_pkg::KIND_HEX, 33'h0_FFFF_FFFF, 1'b0, 3'd0, 8'h00, 8'h00);
    send_op(ssmd_pkg::KIND_HEX, 33'h1_0000_0000, 1'b0, 3'd0, 8'h00, 8'h00);
    send_op(ssmd_pkg::KIND_RAW, 33'd0, 1'b0, 3'd7, 8'hFF, 8'h00);
    send_op(ssmd_pkg::KIND_DP, 33'd0, 1'b0, 3'd0, 8'h00, 8'hAA);
    send_op(ssmd_pkg::KIND_CLEAR, 33'd0, 1'b0, 3'd0, 8'h00, 8'h00);
    send_op(KIND_RSVD_LO, 33'd0, 1'b0, 3'd0, 8'h00, 8'h00);
    send_op(KIND_RSVD_HI, 33'd0, 1'b0, 3'd0, 8'h00, 8'h00);
  endtask

  task automatic test_count_clamping();
    set_config(4'd0, 1'b1);
    send_op(ssmd_pkg::KIND_DEC, 33'd9, 1'b0, 3'd0, 8'h00, 8'h00);
    send_op(ssmd_pkg::KIND_DEC, 33'h1_FFFF_FFFF, 1'b0, 3'd0, 8'h00, 8'h00);
    send_op(ssmd_pkg::KIND_HEX, 33'h10, 1'b0, 3'd0, 8'h00, 8'h00);
    send_op(ssmd_pkg::KIND_RAW, 33'd0, 1'b0, 3'd1, 8'h55, 8'h00);
    send_op(ssmd_pkg::KIND_TICK, 33'd0, 1'b0, 3'd0, 8'h00, 8'h00);
    set_config(4'd15, 1'b0);
    send_op(ssmd_pkg::KIND_DEC, 33'd99999999, 1'b0, 3'd0, 8'h00, 8'h00);
  endtask

  task automatic test_index_beyond_count();
    set_config(4'd8, 1'b0);
    while (act_idx != 3'd7) send_op(ssmd_pkg::KIND_TICK, 33'd0, 1'b0, 3'd0, 8'h00, 8'h00);
    set_config(4'd3, 1'b1);
    send_op(ssmd_pkg::KIND_RAW, 33'd0, 1'b0, 3'd7, 8'h81, 8'h00);
    send_op(ssmd_pkg::KIND_TICK, 33'd0, 1'b0, 3'd0, 8'h00, 8'h00);
  endtask

  task automatic test_output_backpressure();
    int i;
    set_config(4'd6, 1'b0);
    hold_len = 400;
    hold_go = hold_go + 1;
    for (i = 0; i < 40; i++) send_cmd(rand_cmd(used_digits()));
    wait_drain();
  endtask

  task automatic test_random_traffic();
    int p, i;
    logic [3:0] count;
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: count = 4'd1;
        1: count = 4'd8;
        2: count = 4'd0;
        3: count = 4'd15;
        default: count = 4'($urandom_range(0, 15));
      endcase
      set_config(count, (p == 1) ? 1'b1 : 1'($urandom_range(0, 1)));
      no_idle = (p == 4);
      for (i = 0; i < PHASE_ITEMS; i++) send_cmd(rand_cmd(used_digits()));
    end
    no_idle = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < 8; i++) disp_buf[i] = ssmd_pkg::GLYPH_BLANK;
    act_idx = 3'd0;
    cfg_count = 4'd8;
    cfg_ca = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_writes_full_width();
    test_count_clamping();
    test_index_beyond_count();
    test_output_backpressure();
    test_random_traffic();
    wait_drain();
    repeat (30) @(posedge clk);
    if (err_count == 0 && expected_drives.size() == 0) begin
      $display("tb_seven_segment_mux_display_top: PASS");
    end else begin
      $display("tb_seven_segment_mux_display_top: FAIL");
    end
    $finish;
  end

endmodule
